[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/bsgfz_pkg.sv]
// ----------------------------------------------------------------------------
// bsgfz_pkg
// shared types, constants and helpers of the bitmap set/get/find-zero block
// ----------------------------------------------------------------------------
package bsgfz_pkg;

    localparam int POS_W         = 12;
    localparam int POS_LIMIT     = 4096;
    localparam int MAX_WORD_BITS = 64;
    localparam int IDX_W         = 6;

    localparam int NUM_WORDS_DEF = 64;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [POS_W-1:0] bit_pos;
        logic             bit_value;
    } t_in_word;

    typedef struct packed {
        logic             read_bit;
        logic             found;
        logic [POS_W-1:0] found_pos;
    } t_out_word;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_PICK
    } t_state;

    function automatic logic [IDX_W-1:0] f_lowest(input logic [MAX_WORD_BITS-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/bitmap_set_get_find_zero_core.sv]
// ----------------------------------------------------------------------------
// bitmap_set_get_find_zero_core
// bit array with write, read and find-lowest-zero requests
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall / i_in_word carries one request word
// (cmd, bit_pos, bit_value). Output channel: o_out_valid / i_out_stall /
// o_out_word carries one result word (read_bit, found, found_pos) per request.
// A word moves on a rising edge with valid high and stall low.
// Write and read: the store word is read into the store's read register on
// acceptance, then the bit is updated, written back and the result registered.
// Find: the scan reads one word of the store per cycle from word 0 up until a
// word with a zero bit, then encodes its lowest zero; with no zero bit in the
// span the result is not found. SCAN_WORDS is the number of words covering the
// position span (64 by default). One request is in flight at a time: a new
// word is taken only after the last result has gone to the output register.
// Reset: the store is swept to zero, one word per cycle from word 0 to the
// last word, with o_in_stall high throughout.
// Output stall: the result is held in the output register; the next request
// is still taken and runs until its result waits for that register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_set_get_find_zero_core #(
    parameter int NUM_WORDS = bsgfz_pkg::NUM_WORDS_DEF,
    parameter int WORD_BITS = bsgfz_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bsgfz_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bsgfz_pkg::t_out_word o_out_word
);
    import bsgfz_pkg::*;

    localparam int SPAN       = (NUM_WORDS * WORD_BITS < POS_LIMIT) ?
                                (NUM_WORDS * WORD_BITS) : POS_LIMIT;
    localparam int SCAN_WORDS = (SPAN + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (SCAN_WORDS > 1) ? $clog2(SCAN_WORDS) : 1;

    t_mem_ctl             mem_ctl;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 res_valid;
    t_out_word            res_word;
    logic                 out_free;

    logic                 r_out_valid;
    t_out_word            r_out_word;

    bsgfz_mem #(
        .DEPTH (SCAN_WORDS),
        .AW    (AW),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bsgfz_ctrl #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_mem_ctl   (mem_ctl),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res_word  (res_word),
        .i_res_take  (out_free)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_IMPLY(a_read_not_found, i_clk, i_rst_n, o_out_valid && o_out_word.read_bit, !o_out_word.found)
    `ASSERT_IMPLY(a_pos_zero_miss, i_clk, i_rst_n, o_out_valid && !o_out_word.found, o_out_word.found_pos == '0)
    `ASSERT_IMPLY(a_pos_in_span, i_clk, i_rst_n, o_out_valid && o_out_word.found, 13'(o_out_word.found_pos) < 13'(SPAN))
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

[rtl/bsgfz_mem.sv]
// ----------------------------------------------------------------------------
// bsgfz_mem
// bitmap word store, one write and one registered read port
// ----------------------------------------------------------------------------
module bsgfz_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  bsgfz_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    import bsgfz_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bsgfz_ctrl.sv]
// ----------------------------------------------------------------------------
// bsgfz_ctrl
// request sequencer: clearing pass, bit read-modify-write, zero-word scan
// ----------------------------------------------------------------------------
module bsgfz_ctrl #(
    parameter int NUM_WORDS = 64,
    parameter int WORD_BITS = 64,
    parameter int AW        = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  bsgfz_pkg::t_in_word    i_in_word,
    output bsgfz_pkg::t_mem_ctl    o_mem_ctl,
    output logic [AW-1:0]          o_mem_waddr,
    output logic [WORD_BITS-1:0]   o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  logic [WORD_BITS-1:0]   i_mem_rdata,
    output logic                   o_res_valid,
    output bsgfz_pkg::t_out_word   o_res_word,
    input  logic                   i_res_take
);
    import bsgfz_pkg::*;

    localparam int SPAN       = (NUM_WORDS * WORD_BITS < POS_LIMIT) ?
                                (NUM_WORDS * WORD_BITS) : POS_LIMIT;
    localparam int SCAN_WORDS = (SPAN + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_BITS  = SPAN - (SCAN_WORDS - 1) * WORD_BITS;
    localparam int LW         = $clog2(WORD_BITS);
    localparam int SH         = POS_W + LW;
    localparam int RECIP      = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW         = SH + POS_W;

    localparam logic [AW-1:0]        LAST_WORD = AW'(SCAN_WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_PAD  =
        ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));

    t_state r_state, n_state;

    logic [1:0]           r_cmd, n_cmd;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_val, n_val;
    logic [POS_W-1:0]     r_word, n_word;
    logic                 r_inrange, n_inrange;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [AW-1:0]        r_scan_addr, n_scan_addr;
    logic                 r_issue_on, n_issue_on;
    logic                 r_dvalid, n_dvalid;
    logic                 r_dlast, n_dlast;
    logic [POS_W-1:0]     r_base, n_base;
    logic [POS_W-1:0]     r_hit_base, n_hit_base;
    logic [WORD_BITS-1:0] r_zeros, n_zeros;

    logic [PW-1:0]        q_prod;
    logic [POS_W-1:0]     q_word;
    logic                 in_span;
    logic [POS_W-1:0]     rem;
    logic [LW-1:0]        rem_b;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] zeros;

    // word index by reciprocal multiply, exact over the 12-bit position range
    assign q_prod  = PW'(i_in_word.bit_pos) * PW'(RECIP);
    assign q_word  = q_prod[SH +: POS_W];
    assign in_span = (13'(i_in_word.bit_pos) < 13'(SPAN));

    assign rem      = r_pos - POS_W'(r_word * POS_W'(WORD_BITS));
    assign rem_b    = rem[LW-1:0];
    assign bit_mask = WORD_BITS'(1) << rem_b;

    // bits past the addressable span count as set
    assign zeros = ~i_mem_rdata & ~(r_dlast ? LAST_PAD : '0);

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_issue_on <= 1'b0;
            r_dvalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_issue_on <= n_issue_on;
            r_dvalid   <= n_dvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_word      <= n_word;
        r_inrange   <= n_inrange;
        r_scan_addr <= n_scan_addr;
        r_dlast     <= n_dlast;
        r_base      <= n_base;
        r_hit_base  <= n_hit_base;
        r_zeros     <= n_zeros;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_val       = r_val;
        n_word      = r_word;
        n_inrange   = r_inrange;
        n_clr_addr  = r_clr_addr;
        n_scan_addr = r_scan_addr;
        n_issue_on  = r_issue_on;
        n_dvalid    = r_dvalid;
        n_dlast     = r_dlast;
        n_base      = r_base;
        n_hit_base  = r_hit_base;
        n_zeros     = r_zeros;

        o_mem_ctl   = '0;
        o_mem_waddr = r_clr_addr;
        o_mem_wdata = '0;
        o_mem_raddr = q_word[AW-1:0];
        o_res_valid = 1'b0;
        o_res_word  = '0;

        unique case (r_state)
            ST_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                n_clr_addr      = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd       = i_in_word.cmd;
                    n_pos       = i_in_word.bit_pos;
                    n_val       = i_in_word.bit_value;
                    n_word      = q_word;
                    n_inrange   = in_span;
                    n_scan_addr = '0;
                    n_issue_on  = 1'b1;
                    n_dvalid    = 1'b0;
                    n_dlast     = 1'b0;
                    n_base      = '0;
                    o_mem_ctl.rd_en = in_span && ((i_in_word.cmd == CMD_WRITE) ||
                                                  (i_in_word.cmd == CMD_READ));
                    if (i_in_word.cmd == CMD_FIND) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_RMW;
                    end
                end
            end
            ST_RMW: begin
                o_mem_ctl.wr_en = (r_cmd == CMD_WRITE) && r_inrange;
                o_mem_waddr     = r_word[AW-1:0];
                o_mem_wdata     = (i_mem_rdata & ~bit_mask) | (r_val ? bit_mask : '0);
                o_res_valid     = 1'b1;
                o_res_word.read_bit = (r_cmd == CMD_READ) && r_inrange && i_mem_rdata[rem_b];
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_mem_raddr     = r_scan_addr;
                o_mem_ctl.rd_en = r_issue_on;
                n_dvalid        = r_issue_on;
                n_dlast         = r_issue_on && (r_scan_addr == LAST_WORD);
                if (r_issue_on && (r_scan_addr != LAST_WORD)) begin
                    n_scan_addr = r_scan_addr + AW'(1);
                end
                if (r_scan_addr == LAST_WORD) begin
                    n_issue_on = 1'b0;
                end
                if (r_dvalid) begin
                    n_base = r_base + POS_W'(WORD_BITS);
                    if (|zeros) begin
                        n_zeros    = zeros;
                        n_hit_base = r_base;
                        n_issue_on = 1'b0;
                        n_state    = ST_PICK;
                    end else if (r_dlast) begin
                        // every bit in the span is set
                        o_res_valid = 1'b1;
                        n_dvalid    = 1'b1;
                        n_dlast     = 1'b1;
                        if (i_res_take) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_PICK: begin
                o_res_valid          = 1'b1;
                o_res_word.found     = 1'b1;
                o_res_word.found_pos = POS_W'(r_hit_base +
                                              POS_W'(f_lowest(MAX_WORD_BITS'(r_zeros))));
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

endmodule

[bench/bitmap_word_checker.sv]
// ----------------------------------------------------------------------------
// bitmap_word_checker
// Watches both channels of the bitmap core. It keeps its own copy of the bit
// array, works out the result word that each accepted request word should
// give, and compares every accepted result word field by field against the
// oldest outstanding one. It counts the failures for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_word_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  bsgfz_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  bsgfz_pkg::t_out_word i_out_word,
    input  logic                 i_done,
    output int                   o_fail_count
);
    import bsgfz_pkg::*;

    localparam int SPAN_BITS = (NUM_WORDS_DEF * WORD_BITS_DEF < POS_LIMIT) ?
                               NUM_WORDS_DEF * WORD_BITS_DEF : POS_LIMIT;

    logic [POS_LIMIT-1:0] bit_array;
    t_out_word            results_due[$];
    int                   fails = 0;
    int                   results_seen = 0;
    bit                   leftovers_checked = 1'b0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic bitmap_apply(input t_in_word req);
        t_out_word res;
        res = '0;
        case (req.cmd)
            CMD_WRITE: begin
                if (int'(req.bit_pos) < SPAN_BITS) begin
                    bit_array[req.bit_pos] = req.bit_value;
                end
            end
            CMD_READ: begin
                if (int'(req.bit_pos) < SPAN_BITS) begin
                    res.read_bit = bit_array[req.bit_pos];
                end
            end
            CMD_FIND: begin
                for (int p = 0; p < SPAN_BITS; p++) begin
                    if (!bit_array[p]) begin
                        res.found     = 1'b1;
                        res.found_pos = POS_W'(p);
                        break;
                    end
                end
            end
            default: ;
        endcase
        results_due.push_back(res);
    endtask

    task automatic compare_result(input t_out_word got);
        t_out_word want;
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("result word %0d arrived with none outstanding",
                                      results_seen));
        end else begin
            want = results_due.pop_front();
            if (got.read_bit !== want.read_bit) begin
                report_mismatch($sformatf("result %0d read_bit got %0b want %0b",
                                          results_seen, got.read_bit, want.read_bit));
            end
            if (got.found !== want.found) begin
                report_mismatch($sformatf("result %0d found got %0b want %0b",
                                          results_seen, got.found, want.found));
            end
            if (got.found_pos !== want.found_pos) begin
                report_mismatch($sformatf("result %0d found_pos got %0d want %0d",
                                          results_seen, got.found_pos, want.found_pos));
            end
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bit_array = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_result(i_out_word);
            end
            if (i_in_valid && !i_in_stall) begin
                bitmap_apply(i_in_word);
            end
            if (i_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                while (results_due.size() > 0) begin
                    void'(results_due.pop_front());
                    report_mismatch("result word never arrived");
                end
            end
        end
    end

endmodule

[bench/tb_bitmap_set_get_find_zero_core.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_set_get_find_zero_core
// Drives write, read and find-lowest-zero request words into the bitmap core
// with bursty input and a patterned output stall. A short directed run covers
// the position extremes, the unused command code and the empty case; the
// random run fills words from the bottom up so finds scan deep, mixed with
// reads, stray writes and noise; a short tail pokes single bits. Checking
// is done by bitmap_word_checker beside the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_set_get_find_zero_core;

    import bsgfz_pkg::*;

    localparam logic [1:0] CMD_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         RANDOM_WORDS = 950;
    localparam int         DRAIN_CYCLES = 100;
    localparam int         HOLD_CYCLES  = 300;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    logic      checks_done = 1'b0;
    int        fail_count;

    int words_in     = 0;
    int words_out    = 0;
    int burst_left   = 0;
    int filled_words = 0;
    int hold_count   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bitmap_set_get_find_zero_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    bitmap_word_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_done       (checks_done),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                words_in <= words_in + 1;
            end
            if (out_valid && !out_stall) begin
                words_out <= words_out + 1;
            end
        end
    end

    // output stall pattern, with an occasional long hold on request
    initial begin : out_stall_gen
        int mode;
        int span_left;
        int hold_left;
        int holds_taken;
        mode        = 0;
        span_left   = 0;
        hold_left   = 0;
        holds_taken = 0;
        forever begin
            @(posedge clk);
            if (hold_count != holds_taken && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                holds_taken++;
            end
            if (span_left == 0) begin
                mode      = $urandom_range(0, 3);
                span_left = $urandom_range(16, 96);
            end
            span_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("bitmap_set_get_find_zero_core verification failed");
        $finish;
    end

    task automatic push_word(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= '{cmd: cmd, bit_pos: pos, bit_value: val};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (words_in != words_out) @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int k;
        int top;
        k   = $urandom_range(0, 9);
        top = (filled_words + 1) * WORD_BITS_DEF - 1;
        if (top > POS_LIMIT - 1) begin
            top = POS_LIMIT - 1;
        end
        if (k < 6) begin
            return POS_W'($urandom_range(0, top));
        end else if (k < 8) begin
            return POS_W'($urandom_range(0, POS_LIMIT - 1));
        end else if (k == 8) begin
            return ($urandom_range(0, 1) == 0) ? '0 : '1;
        end
        return POS_W'($urandom_range(0, NUM_WORDS_DEF - 1) * WORD_BITS_DEF
                      + ($urandom_range(0, 1) ? WORD_BITS_DEF - 1 : 0));
    endfunction

    // set every bit of one word in scrambled order, maybe leaving one hole
    task automatic fill_word(input int w, input bit leave_hole);
        int start;
        int stride;
        int hole;
        int b;
        start  = $urandom_range(0, WORD_BITS_DEF - 1);
        stride = 2 * $urandom_range(0, WORD_BITS_DEF / 2 - 1) + 1;
        hole   = leave_hole ? $urandom_range(0, WORD_BITS_DEF - 1) : -1;
        for (int k = 0; k < WORD_BITS_DEF; k++) begin
            b = (start + stride * k) % WORD_BITS_DEF;
            if (b != hole) begin
                push_word(CMD_WRITE, POS_W'(w * WORD_BITS_DEF + b), 1'b1);
            end
        end
        push_word(CMD_FIND, POS_W'($urandom), 1'($urandom));
        if (leave_hole) begin
            push_word(CMD_READ, POS_W'(w * WORD_BITS_DEF + hole), 1'b0);
        end
    endtask

    task automatic mixed_run(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_word(CMD_WRITE, pick_position(), ($urandom_range(0, 4) != 0));
            end else if (r < 60) begin
                push_word(CMD_READ, pick_position(), 1'($urandom));
            end else if (r < 90) begin
                push_word(CMD_FIND, POS_W'($urandom), 1'($urandom));
            end else begin
                push_word(CMD_SPARE, POS_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int seq;
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty array, extremes, spare code, ignored fields
        push_word(CMD_READ,  12'd0,    1'b0);
        push_word(CMD_READ,  12'd4095, 1'b0);
        push_word(CMD_FIND,  12'd0,    1'b0);
        push_word(CMD_WRITE, 12'd0,    1'b1);
        push_word(CMD_READ,  12'd0,    1'b0);
        push_word(CMD_FIND,  12'd4095, 1'b1);
        push_word(CMD_WRITE, 12'd4095, 1'b1);
        push_word(CMD_READ,  12'd4095, 1'b0);
        push_word(CMD_WRITE, 12'd1,    1'b1);
        push_word(CMD_FIND,  12'd0,    1'b0);
        push_word(CMD_WRITE, 12'd63,   1'b1);
        push_word(CMD_WRITE, 12'd0,    1'b0);
        push_word(CMD_FIND,  12'd0,    1'b0);
        push_word(CMD_READ,  12'd63,   1'b1);
        push_word(CMD_SPARE, 12'd0,    1'b1);
        push_word(CMD_READ,  12'd0,    1'b0);
        push_word(CMD_SPARE, 12'd4095, 1'b0);
        push_word(CMD_READ,  12'd4095, 1'b0);
        push_word(CMD_WRITE, 12'd4095, 1'b0);
        push_word(CMD_READ,  12'd4095, 1'b0);
        push_word(CMD_READ,  12'd2,    1'b1);
        push_word(CMD_WRITE, 12'd1,    1'b0);
        push_word(CMD_WRITE, 12'd63,   1'b0);
        push_word(CMD_FIND,  12'd0,    1'b0);

        // random part: grow a prefix of full words, mixed with other traffic
        target = words_in + RANDOM_WORDS;
        seq    = 0;
        while (words_in < target) begin
            if (seq == 5) begin
                hold_count++;
            end
            if (seq == 10) begin
                wait_idle();
            end
            if ($urandom_range(0, 9) < 3) begin
                fill_word(filled_words, ($urandom_range(0, 2) == 0));
                filled_words = (filled_words + 1) % NUM_WORDS_DEF;
            end else begin
                mixed_run($urandom_range(6, 16));
            end
            seq++;
        end

        // single bits at the top and the middle
        push_word(CMD_FIND,  12'd0,    1'b0);
        push_word(CMD_READ,  12'd4095, 1'b0);
        push_word(CMD_WRITE, 12'd4095, 1'b0);
        push_word(CMD_FIND,  12'd0,    1'b0);
        push_word(CMD_WRITE, 12'd2048, 1'b0);
        push_word(CMD_FIND,  12'd4095, 1'b1);
        push_word(CMD_WRITE, 12'd2048, 1'b1);
        push_word(CMD_WRITE, 12'd4095, 1'b1);
        push_word(CMD_FIND,  12'd0,    1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        checks_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0) begin
            $display("bitmap_set_get_find_zero_core verification clean");
        end else begin
            $display("bitmap_set_get_find_zero_core verification failed");
        end
        $finish;
    end

endmodule

[bitmap_set_get_find_zero_core.f]
+incdir+rtl
rtl/bsgfz_pkg.sv
rtl/bsgfz_mem.sv
rtl/bsgfz_ctrl.sv
rtl/bitmap_set_get_find_zero_core.sv
bench/bitmap_word_checker.sv
bench/tb_bitmap_set_get_find_zero_core.sv
